[design/cunrank_pkg.sv]
// ----------------------------------------------------------------------------
// cunrank_pkg
// Shared types, field widths and binomial helpers for the combination
// unranking block.
// ----------------------------------------------------------------------------
package cunrank_pkg;

   // Field widths of the request and response words
   localparam int SIZE_W = 3;
   localparam int RANK_W = 22;
   localparam int MASK_W = 52;

   // Default deck and subset limits
   localparam int NUM_CARDS_DEF = 52;
   localparam int MAX_PICK_DEF  = 5;

   // Request word: subset size and lexicographic rank
   typedef struct packed {
      logic [SIZE_W-1:0] hand_size;
      logic [RANK_W-1:0] rank_index;
   } req_type;

   // Response word: chosen cards and range flag
   typedef struct packed {
      logic [MASK_W-1:0] card_mask;
      logic              index_valid;
   } rsp_type;

   // C(n, k) for k up to 8 by Pascal's rule; 0 when k > n or k is negative.
   // Elaboration use only.
   function automatic longint unsigned binom(int n, int k);
      longint unsigned row [0:8];
      for (int j = 0; j <= 8; j++) begin
         row[j] = 0;
      end
      row[0] = 1;
      for (int i = 1; i <= n; i++) begin
         for (int j = 8; j >= 1; j--) begin
            row[j] = row[j] + row[j-1];
         end
      end
      if (k < 0 || k > 8) begin
         return 0;
      end
      return row[k];
   endfunction

   // Largest C(n, k) over n <= n_cards, k <= max_pick: sets the table width
   function automatic longint unsigned max_binom(int n_cards, int max_pick);
      longint unsigned best;
      longint unsigned val;
      best = 1;
      for (int n = 0; n <= n_cards; n++) begin
         for (int k = 0; k <= max_pick; k++) begin
            val = binom(n, k);
            if (val > best) begin
               best = val;
            end
         end
      end
      return best;
   endfunction

endpackage

[design/cunrank_ram.sv]
// ----------------------------------------------------------------------------
// cunrank_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cunrank_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry in the cycle after its address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/combination_unrank_to_mask_top.sv]
// ----------------------------------------------------------------------------
// combination_unrank_to_mask_top
// Turns a subset size and lexicographic rank into the bit mask of the chosen
// cards, walking the deck from card 0 upward with a binomial table in RAM.
// ----------------------------------------------------------------------------
// Usage: pulse start with a request word while busy is low. Each item first
// reads C(NUM_CARDS,size) from the binomial RAM for the range check, then
// walks the deck one card per cycle, each card with one RAM read, one compare
// and one subtract; the walk ends at the last card taken. The range check
// alone (size zero, rank or size out of range) ends the item with no walk.
// The single read port of the binomial RAM sets this pace. After reset a
// fill pass loads the table while busy stays high. Each result shows on
// rsp_data for exactly one cycle with rsp_valid high; the receiver cannot
// stall it, and a new start is taken in that same cycle.
// ----------------------------------------------------------------------------
module combination_unrank_to_mask_top #(
   parameter int NUM_CARDS = cunrank_pkg::NUM_CARDS_DEF,
   parameter int MAX_PICK  = cunrank_pkg::MAX_PICK_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cunrank_pkg::req_type req_data,
   output logic                 rsp_valid,
   output cunrank_pkg::rsp_type rsp_data
);

   import cunrank_pkg::*;

   // Table geometry: address is {n, k}, word is {C(n,k), C(n,k-1)}
   localparam int NW    = $clog2(NUM_CARDS + 1);
   localparam int KW    = (MAX_PICK < 2) ? 1 : $clog2(MAX_PICK + 1);
   localparam int AW    = NW + KW;
   localparam int DEPTH = 2 ** AW;
   localparam int BW    = $clog2(max_binom(NUM_CARDS, MAX_PICK) + 1);
   localparam int CW    = (BW > RANK_W) ? BW : RANK_W;
   localparam int CARDW = $clog2(NUM_CARDS);

   typedef enum logic [1:0] {
      FILL,
      IDLE,
      CHECK,
      WALK
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      fill_cnt_ff, fill_cnt_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic               reject_ff, reject_in;
   logic [RANK_W-1:0]  rank_ff, rank_in;
   logic [KW-1:0]      left_ff, left_in;
   logic [CARDW-1:0]   card_ff, card_in;
   logic               taken_ff, taken_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [BW-1:0]      row_ff [2**KW];
   logic [BW-1:0]      row_in [2**KW];

   logic               ram_wr_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [2*BW-1:0]    ram_rd_data;
   logic [NW-1:0]      fill_n;
   logic [KW-1:0]      fill_k;
   logic               fill_on;
   logic [BW-1:0]      fill_hi;
   logic [BW-1:0]      fill_lo;
   logic [BW-1:0]      binom_hi;
   logic [BW-1:0]      binom_lo;
   logic [BW-1:0]      with_card;
   logic               take;
   logic [KW-1:0]      left_next;
   logic               accept;

   // Binomial table storage
   cunrank_ram #(
      .WIDTH (2 * BW),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (fill_cnt_ff),
      .wr_data ({fill_hi, fill_lo}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Form the fill word from the current Pascal row; unused slots get zero
   assign fill_n  = fill_cnt_ff[AW-1:KW];
   assign fill_k  = fill_cnt_ff[KW-1:0];
   assign fill_on = (fill_n <= NW'(NUM_CARDS)) && (32'(fill_k) <= MAX_PICK);
   assign fill_hi = fill_on ? row_ff[fill_k] : '0;
   assign fill_lo = (fill_on && fill_k != '0) ? row_ff[fill_k - KW'(1)] : '0;

   // Advance the row to n+1 by Pascal's rule after the last k of row n
   always_comb begin
      row_in = row_ff;
      if (state_ff == FILL && fill_k == '1) begin
         for (int j = 1; j <= MAX_PICK; j++) begin
            row_in[j] = row_ff[j] + row_ff[j-1];
         end
      end
   end

   assign ram_wr_en = (state_ff == FILL);
   assign accept    = start && (state_ff == IDLE);
   assign binom_hi  = ram_rd_data[2*BW-1:BW];
   assign binom_lo  = ram_rd_data[BW-1:0];

   // Pick the count for this card: drop to k-1 when the last card was taken
   assign with_card = taken_ff ? binom_lo : binom_hi;
   assign take      = CW'(rank_ff) < CW'(with_card);
   assign left_next = left_ff - KW'(take);

   // Next state, read address and result
   always_comb begin
      state_in     = state_ff;
      fill_cnt_in  = fill_cnt_ff;
      size_in      = size_ff;
      reject_in    = reject_ff;
      rank_in      = rank_ff;
      left_in      = left_ff;
      card_in      = card_ff;
      taken_in     = taken_ff;
      mask_in      = mask_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ram_rd_addr  = '0;

      unique case (state_ff)
         FILL: begin
            fill_cnt_in = fill_cnt_ff + AW'(1);
            if (fill_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            // Read C(NUM_CARDS, size) for the range check
            ram_rd_addr = {NW'(NUM_CARDS), KW'(req_data.hand_size)};
            if (accept) begin
               size_in   = req_data.hand_size;
               reject_in = (32'(req_data.hand_size) > MAX_PICK);
               rank_in   = req_data.rank_index;
               state_in  = CHECK;
            end
         end
         CHECK: begin
            // Prefetch the count for card 0
            ram_rd_addr = {NW'(NUM_CARDS - 1), KW'(size_ff) - KW'(1)};
            left_in     = KW'(size_ff);
            card_in     = '0;
            taken_in    = 1'b0;
            mask_in     = '0;
            if (reject_ff || !(CW'(rank_ff) < CW'(binom_hi))) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.card_mask   = '0;
               rsp_data_in.index_valid = 1'b0;
               state_in                = IDLE;
            end else if (size_ff == '0) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.card_mask   = '0;
               rsp_data_in.index_valid = 1'b1;
               state_in                = IDLE;
            end else begin
               state_in = WALK;
            end
         end
         WALK: begin
            // Take the card or skip past its subsets
            if (take) begin
               if (32'(card_ff) < MASK_W) begin
                  mask_in = mask_ff | (MASK_W'(1) << card_ff);
               end
            end else begin
               rank_in = RANK_W'(CW'(rank_ff) - CW'(with_card));
            end
            left_in  = left_next;
            taken_in = take;
            if (left_next == '0 || card_ff == CARDW'(NUM_CARDS - 1)) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.card_mask   = take && (32'(card_ff) < MASK_W) ?
                                         (mask_ff | (MASK_W'(1) << card_ff)) : mask_ff;
               rsp_data_in.index_valid = 1'b1;
               state_in                = IDLE;
            end else begin
               // Prefetch {C(n,left-1), C(n,left-2)} for the next card
               ram_rd_addr = {NW'(NUM_CARDS - 2) - NW'(card_ff), left_ff - KW'(1)};
               card_in     = card_ff + CARDW'(1);
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FILL;
         fill_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < 2**KW; j++) begin
            row_ff[j] <= (j == 0) ? BW'(1) : '0;
         end
      end else begin
         state_ff     <= state_in;
         fill_cnt_ff  <= fill_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         row_ff       <= row_in;
      end
      size_ff     <= size_in;
      reject_ff   <= reject_in;
      rank_ff     <= rank_in;
      left_ff     <= left_in;
      card_ff     <= card_in;
      taken_ff    <= taken_in;
      mask_ff     <= mask_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // A result word lands only when the block is back at idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == IDLE))
      else $error("response strobe outside idle");

   // An accepted word keeps the block busy on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy did not rise after accept");

   // An out-of-range word carries an empty mask
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.index_valid) |-> (rsp_data_ff.card_mask == '0))
      else $error("rejected word with nonzero mask");

   // The walk never runs with no cards left to pick
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == WALK) |-> (left_ff != '0))
      else $error("walk with nothing left to pick");

   // A valid mask holds exactly hand_size cards when the deck fits the mask
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.index_valid && (NUM_CARDS <= MASK_W)) |->
         ($countones(rsp_data_ff.card_mask) == 32'(size_ff)))
      else $error("mask population differs from hand size");
`endif

endmodule

[test/combination_unrank_to_mask_top_tb.sv]
// ----------------------------------------------------------------------------
// combination_unrank_to_mask_top_tb
// Sends subset size and rank words to the unranking block and checks every
// returned card mask and range flag against a walk of the deck done here.
// Starts with boundary ranks for every legal size, then runs random words,
// mostly in-range ranks, under several sender idle patterns.
// ----------------------------------------------------------------------------
module combination_unrank_to_mask_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cunrank_pkg::*;

   localparam int DECK      = NUM_CARDS_DEF;
   localparam int PICK_MAX  = MAX_PICK_DEF;
   localparam int RANK_TOP  = (1 << RANK_W) - 1;
   localparam int SIZE_TOP  = (1 << SIZE_W) - 1;
   localparam int WALK_SLACK = DECK + 8;

   // Expected card masks, held in the order the words were taken
   class mask_scoreboard;
      rsp_type pending_masks[$];
      int      mismatches;

      function new();
         mismatches = 0;
      endfunction

      // C(n, k) by the multiplicative rule; every step divides exactly
      static function longint unsigned choose_count(int n, int k);
         longint unsigned r;
         r = 1;
         if (n < 0 || k < 0 || k > n) begin
            return 0;
         end
         for (int i = 0; i < k; i++) begin
            r = r * longint'(n - i) / longint'(i + 1);
         end
         return r;
      endfunction

      // Walk the deck from card 0 up, taking a card while the rank falls
      // inside the subsets that hold it
      static function rsp_type unrank_cards(req_type w);
         rsp_type         res;
         longint unsigned rank_left;
         longint unsigned with_card;
         int              left;
         res = '0;
         rank_left = longint'(w.rank_index);
         left = int'(w.hand_size);
         if (left <= PICK_MAX && rank_left < choose_count(DECK, left)) begin
            res.index_valid = 1'b1;
            for (int card = 0; card < DECK && left > 0; card++) begin
               with_card = choose_count(DECK - card - 1, left - 1);
               if (rank_left < with_card) begin
                  if (card < MASK_W) begin
                     res.card_mask[card] = 1'b1;
                  end
                  left--;
               end else begin
                  rank_left -= with_card;
               end
            end
         end
         return res;
      endfunction

      function int outstanding();
         return pending_masks.size();
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= 40) begin
            $display("%0t mismatch: %s", $realtime, what);
         end
      endtask

      function void note_request(req_type w);
         pending_masks.push_back(unrank_cards(w));
      endfunction

      task check_result(rsp_type got);
         rsp_type want;
         if (pending_masks.size() == 0) begin
            report_mismatch($sformatf("unexpected word mask=%h valid=%b",
                                      got.card_mask, got.index_valid));
         end else begin
            want = pending_masks.pop_front();
            if (got.card_mask !== want.card_mask) begin
               report_mismatch($sformatf("card_mask got %h want %h",
                                         got.card_mask, want.card_mask));
            end
            if (got.index_valid !== want.index_valid) begin
               report_mismatch($sformatf("index_valid got %b want %b",
                                         got.index_valid, want.index_valid));
            end
         end
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   mask_scoreboard sb;

   combination_unrank_to_mask_top #(
      .NUM_CARDS (DECK),
      .MAX_PICK  (PICK_MAX)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Check each result word in the cycle it shows
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         sb.check_result(rsp_data);
      end
   end

   // Hold the word on the port until the block takes it
   task send_word(input req_type w);
      start    <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy !== 1'b0) begin
         @(posedge clock);
      end
      sb.note_request(w);
   endtask

   task idle_gap(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start and hold until every expected word has come back
   task drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic req_type build_word(int size, longint unsigned rank);
      req_type w;
      w.hand_size  = size[SIZE_W-1:0];
      w.rank_index = rank[RANK_W-1:0];
      return w;
   endfunction

   // Mostly in-range ranks for legal sizes; the rest boundaries and noise
   function automatic req_type random_word();
      int              size;
      int              pick;
      longint unsigned count;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         size  = $urandom_range(1, PICK_MAX);
         count = mask_scoreboard::choose_count(DECK, size);
         return build_word(size, $urandom_range(0, int'(count) - 1));
      end else if (pick < 85) begin
         size  = $urandom_range(0, PICK_MAX);
         count = mask_scoreboard::choose_count(DECK, size);
         return build_word(size, count - 1 + $urandom_range(0, 1));
      end
      return build_word($urandom_range(0, SIZE_TOP), $urandom_range(0, RANK_TOP));
   endfunction

   // Run one stretch of random words with the given idle share
   task run_phase(input int words, input int idle_pct);
      for (int i = 0; i < words; i++) begin
         send_word(random_word());
         if ($urandom_range(0, 99) < idle_pct) begin
            idle_gap($urandom_range(1, 60));
         end
      end
   endtask

   // Reset, directed boundaries, random phases, then the final verdict
   initial begin
      longint unsigned count;
      int              idle_share [4];
      sb       = new();
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first, last and first-out-of-range rank for each legal size
      for (int size = 0; size <= PICK_MAX; size++) begin
         count = mask_scoreboard::choose_count(DECK, size);
         send_word(build_word(size, 0));
         send_word(build_word(size, count - 1));
         send_word(build_word(size, count));
      end
      // rejected sizes, top rank and alternating rank bits
      send_word(build_word(PICK_MAX + 1, 0));
      send_word(build_word(PICK_MAX + 1, 1));
      send_word(build_word(SIZE_TOP, RANK_TOP));
      send_word(build_word(PICK_MAX, RANK_TOP));
      send_word(build_word(PICK_MAX, 22'h155555));
      send_word(build_word(PICK_MAX, 22'h2AAAAA));
      drain_results();

      // no idling, sender idle often, sender idle now and then, none again
      idle_share[0] = 0;
      idle_share[1] = 45;
      idle_share[2] = 17;
      idle_share[3] = 0;
      for (int ph = 0; ph < 4; ph++) begin
         run_phase(232, idle_share[ph]);
         drain_results();
      end

      repeat (WALK_SLACK) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

endmodule

[sim.f]
design/cunrank_pkg.sv
design/cunrank_ram.sv
design/combination_unrank_to_mask_top.sv
test/combination_unrank_to_mask_top_tb.sv
